// File: rtl/spcl_pkg.sv
// ---------------------------------------------------------------------------
// spcl_pkg: shared definitions for the prime-count lookup unit
// Field widths, the default table bound and the sieve sequencer states.
// ---------------------------------------------------------------------------
package spcl_pkg;

  localparam int QUERY_W        = 17;
  localparam int THRESH_W       = 32;
  localparam int COUNT_W        = 16;
  localparam int S_TDATA_W      = 56;
  localparam int M_TDATA_W      = 24;
  localparam int DEF_MAX_VALUE  = 65536;

  // Sieve sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_PRIME_RD = 7'b0000010,
    S_PRIME_CK = 7'b0000100,
    S_MARK     = 7'b0001000,
    S_COUNT    = 7'b0010000,
    S_DRAIN    = 7'b0100000,
    S_DONE     = 7'b1000000
  } sieve_state_t;

endpackage

// File: rtl/spcl_ram.sv
// ---------------------------------------------------------------------------
// spcl_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and held while
// no read is enabled.
// ---------------------------------------------------------------------------
module spcl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/spcl_sieve.sv
// ---------------------------------------------------------------------------
// spcl_sieve: sieve sequencer and prime-count table writer
// Runs the clearing/even pass, the odd-prime marking pass and the counting
// pass over the mark memory, and writes the running counts out.
// ---------------------------------------------------------------------------
module spcl_sieve
  import spcl_pkg::*;
#(
  parameter int MAX_VALUE = DEF_MAX_VALUE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  output logic                                 done,
  output logic                                 cnt_we,
  output logic [$clog2(MAX_VALUE + 1)-1:0]     cnt_waddr,
  output logic [$clog2(MAX_VALUE + 1)-1:0]     cnt_wdata
);

  localparam int ADDR_W = $clog2(MAX_VALUE + 1);
  localparam int JW     = ADDR_W + 1;

  sieve_state_t state;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] odd;
  logic [JW-1:0]     sq;
  logic [JW-1:0]     mul;
  logic [JW-1:0]     step;
  logic              rd_vld;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] running;
  logic [ADDR_W-1:0] running_next;

  logic              mk_we;
  logic [ADDR_W-1:0] mk_waddr;
  logic              mk_wdata;
  logic              mk_re;
  logic [ADDR_W-1:0] mk_raddr;
  logic              mk_rdata;

  logic [JW-1:0]     sq_next;
  logic              prime_inc;

  spcl_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VALUE + 1)
  ) u_marks (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .re    (mk_re),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  // (i+2)^2 = i^2 + 4i + 4
  assign sq_next = sq + JW'({odd, 2'b00}) + JW'(4);

  assign prime_inc    = rd_vld && (rd_addr >= ADDR_W'(2)) && !mk_rdata;
  assign running_next = running + ADDR_W'(prime_inc);

  assign cnt_we    = rd_vld;
  assign cnt_waddr = rd_addr;
  assign cnt_wdata = running_next;
  assign done      = (state == S_DONE);

  always_comb begin
    mk_we    = 1'b0;
    mk_waddr = addr;
    mk_wdata = 1'b0;
    mk_re    = 1'b0;
    mk_raddr = addr;
    case (state)
      S_CLEAR: begin
        mk_we    = 1'b1;
        mk_wdata = !addr[0] && (addr >= ADDR_W'(4));
      end
      S_PRIME_RD: begin
        mk_re    = (sq <= JW'(MAX_VALUE));
        mk_raddr = odd;
      end
      S_MARK: begin
        mk_we    = (mul <= JW'(MAX_VALUE));
        mk_waddr = mul[ADDR_W-1:0];
        mk_wdata = 1'b1;
      end
      S_COUNT: begin
        mk_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      addr    <= '0;
      odd     <= ADDR_W'(3);
      sq      <= JW'(9);
      rd_vld  <= 1'b0;
      running <= '0;
    end else begin
      rd_vld <= 1'b0;
      if (rd_vld) begin
        running <= running_next;
      end
      case (state)
        S_CLEAR: begin
          if (addr == ADDR_W'(MAX_VALUE)) begin
            state <= S_PRIME_RD;
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        S_PRIME_RD: begin
          if (sq > JW'(MAX_VALUE)) begin
            addr  <= '0;
            state <= S_COUNT;
          end else begin
            state <= S_PRIME_CK;
          end
        end
        S_PRIME_CK: begin
          if (!mk_rdata) begin
            mul   <= sq;
            step  <= JW'({odd, 1'b0});
            state <= S_MARK;
          end else begin
            odd   <= odd + ADDR_W'(2);
            sq    <= sq_next;
            state <= S_PRIME_RD;
          end
        end
        S_MARK: begin
          if (mul <= JW'(MAX_VALUE)) begin
            mul <= mul + step;
          end else begin
            odd   <= odd + ADDR_W'(2);
            sq    <= sq_next;
            state <= S_PRIME_RD;
          end
        end
        S_COUNT: begin
          rd_vld  <= 1'b1;
          rd_addr <= addr;
          if (addr == ADDR_W'(MAX_VALUE)) begin
            state <= S_DRAIN;
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// File: rtl/sieve_prime_count_lookup_unit.sv
// ---------------------------------------------------------------------------
// sieve_prime_count_lookup_unit: prime-count lookup with built-in sieve
// Answers pi(x) queries from a table that a sieve of Eratosthenes fills
// after reset.
// ---------------------------------------------------------------------------
// Usage
//   Queries arrive as words on the s_ stream (query value and threshold) and
//   each query gives exactly one result word on the m_ stream: pi(x), a flag
//   set when pi(x) exceeds the threshold, and an out-of-range flag for a
//   query above MAX_VALUE (the count then reads as zero).
//   After reset s_tready stays low while the sieve builds the tables in a
//   clearing pass, which also marks the even numbers, then a marking pass
//   that checks each odd candidate up to sqrt(MAX_VALUE) and marks the odd
//   multiples of each odd prime among them, and a counting pass that writes
//   the count table.
//   Once ready, the block takes one word per cycle while the receiver does
//   not stall. The count table read is registered, and the result word then
//   passes through the output register before it is valid on m_.
//   A one-deep read stage and the output register keep the flow going; when
//   the receiver stalls, the output register and then the read stage hold
//   their words and s_tready drops, so no word is lost. The rate is set by
//   the single read port of the count table memory.
// ---------------------------------------------------------------------------
module sieve_prime_count_lookup_unit
  import spcl_pkg::*;
#(
  parameter int MAX_VALUE = DEF_MAX_VALUE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // query_value [16:0], threshold [48:17], zero [55:49]
  input  logic [S_TDATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // prime_count [15:0], count_exceeds [16], out_of_range [17], zero [23:18]
  output logic [M_TDATA_W-1:0]  m_tdata
);

  localparam int ADDR_W = $clog2(MAX_VALUE + 1);
  localparam int XW     = (ADDR_W > QUERY_W) ? ADDR_W : QUERY_W;

  logic                table_ready;
  logic                cnt_we;
  logic [ADDR_W-1:0]   cnt_waddr;
  logic [ADDR_W-1:0]   cnt_wdata;
  logic [ADDR_W-1:0]   cnt_rdata;

  logic [QUERY_W-1:0]  query_value;
  logic [THRESH_W-1:0] threshold;
  logic [XW-1:0]       query_ext;
  logic                in_accept;
  logic                advance;

  // Read stage: a table read is in flight or its data is being held.
  logic                rd_vld;
  logic                rd_oor;
  logic [THRESH_W-1:0] rd_thresh;

  // Output register.
  logic                out_vld;
  logic [COUNT_W-1:0]  out_count;
  logic                out_exceeds;
  logic                out_oor;

  logic [31:0]         count_full;

  assign query_value = s_tdata[QUERY_W-1:0];
  assign threshold   = s_tdata[QUERY_W+THRESH_W-1:QUERY_W];
  assign query_ext   = XW'(query_value);

  // The read stage moves on when the output register is empty or drained.
  assign advance   = !out_vld || m_tready;
  assign s_tready  = table_ready && (!rd_vld || advance);
  assign in_accept = s_tvalid && s_tready;

  spcl_sieve #(
    .MAX_VALUE (MAX_VALUE)
  ) u_sieve (
    .clk       (clk),
    .rst       (rst),
    .done      (table_ready),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata)
  );

  // The read data stays put while no new query is accepted, which lets the
  // read stage hold its word during a stall.
  spcl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_VALUE + 1)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_accept),
    .raddr (query_ext[ADDR_W-1:0]),
    .rdata (cnt_rdata)
  );

  assign count_full = 32'(cnt_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_vld <= 1'b1;
      end else if (advance) begin
        rd_vld <= 1'b0;
      end
      if (advance) begin
        out_vld <= rd_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_oor    <= (query_ext > XW'(MAX_VALUE));
      rd_thresh <= threshold;
    end
    if (advance && rd_vld) begin
      if (rd_oor) begin
        out_count   <= '0;
        out_exceeds <= 1'b0;
        out_oor     <= 1'b1;
      end else begin
        // Counts above the field saturate; the compare sees the full count.
        out_count   <= (count_full > 32'hFFFF) ? 16'hFFFF : count_full[COUNT_W-1:0];
        out_exceeds <= (count_full > rd_thresh);
        out_oor     <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {6'b000000, out_oor, out_exceeds, out_count};

  // No query may enter before the tables are complete.
  a_no_early_query: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> table_ready)
    else $error("query accepted before the sieve finished");

  // Once built, the tables stay valid until the next reset.
  a_ready_sticks: assert property (@(posedge clk) disable iff (rst)
    table_ready |=> table_ready)
    else $error("table ready flag dropped");

  // A held read must not be overwritten by a new query.
  a_read_held: assert property (@(posedge clk) disable iff (rst)
    (rd_vld && !advance) |-> !in_accept)
    else $error("query accepted over a stalled read");

  // Out-of-range results carry a zero count and no exceed flag.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_oor) |-> (out_count == '0 && !out_exceeds))
    else $error("out-of-range result with a non-zero count");

endmodule
